// File: design/dqve_pkg.sv
`timescale 1ns / 1ps
package dqve_pkg;

    // Fraction bits of the speed outputs
    localparam int FRAC_BITS = 16;

    localparam int POS_W     = 32;               // counts, speeds, timestamps
    localparam int MAG_W     = POS_W;            // magnitude of a delta count
    localparam int CFG_W     = 16;               // widest configuration register
    localparam int CFG_IDX_W = 3;
    localparam int CMD_W     = 2;
    localparam int DEN_W     = CFG_W + POS_W;    // counts_per_rev * elapsed ms
    localparam int KTP_W     = 42;               // 1000 * 2*pi in Q29
    localparam int K_W       = KTP_W + CFG_W;    // multiplicand incl. wheel radius
    localparam int PROD_W    = MAG_W + K_W;
    localparam int NUM_W     = PROD_W + FRAC_BITS + 1;
    localparam int Q_W       = POS_W + 2;        // doubled quotient before rounding
    localparam int STEP_W    = $clog2(Q_W);

    // Doubled quotient 2A/B: scale by 2^(FRAC_BITS+1) over 2^29, 2^0 and 2^45
    localparam int SH_RAD = 28 - FRAC_BITS;
    localparam int SH_RPM = FRAC_BITS + 1;
    localparam int SH_MPS = 44 - FRAC_BITS;

    localparam logic [63:0] TWO_PI_Q29 = 64'd3373259426;
    localparam logic [63:0] MS_PER_S   = 64'd1000;
    localparam logic [63:0] MS_PER_MIN = 64'd60000;
    localparam logic [K_W-1:0] K_RAD = K_W'(TWO_PI_Q29 * MS_PER_S);
    localparam logic [K_W-1:0] K_RPM = K_W'(MS_PER_MIN);

    localparam logic [CFG_W-1:0] CPR_RESET    = 16'd1320;
    localparam logic [CFG_W-1:0] PERIOD_RESET = 16'd50;
    localparam logic [CFG_W-1:0] RADIUS_RESET = 16'd2130;

    localparam logic [CMD_W-1:0] CMD_EDGE   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_UPDATE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SET    = 2'd2;
    localparam logic [CMD_W-1:0] CMD_RESET  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_CPR    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LINV   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RINV   = 3'd4;

    // Speed unit operations; the first three also index a wheel's speed triple
    typedef enum logic [1:0] {
        OP_RAD = 2'd0,
        OP_RPM = 2'd1,
        OP_MPS = 2'd2,
        OP_KMS = 2'd3
    } t_op;

    typedef struct packed {
        logic             start;
        t_op              op;
        logic [MAG_W-1:0] mag;
        logic             neg;
    } t_speed_req;

    typedef struct packed {
        logic             done;
        logic [POS_W-1:0] value;
    } t_speed_rsp;

endpackage

// File: design/dqve_speed_unit.sv
`timescale 1ns / 1ps
module dqve_speed_unit
    import dqve_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_speed_req       i_req,
    input  logic [DEN_W-1:0] i_den,
    input  logic [CFG_W-1:0] i_radius,
    output t_speed_rsp       o_rsp
);

    typedef enum logic [5:0] {
        U_IDLE = 6'b000001,
        U_MUL  = 6'b000010,
        U_CHK  = 6'b000100,
        U_DIV  = 6'b001000,
        U_RND  = 6'b010000,
        U_FIN  = 6'b100000
    } t_unit_state;

    t_unit_state r_state, n_state;

    t_op               r_op;
    logic              r_neg;
    logic [MAG_W-1:0]  r_ma;
    logic [K_W-1:0]    r_mb;
    logic [K_W-1:0]    r_kms;
    logic [PROD_W-1:0] r_acc;
    logic [DEN_W-1:0]  r_rem;
    logic [Q_W-1:0]    r_num;
    logic              r_ovf;
    logic [STEP_W-1:0] r_step;
    logic [POS_W-1:0]  r_val;

    logic [K_W-1:0]         mb_sel;
    logic [NUM_W-1:0]       num_aligned;
    logic [NUM_W-Q_W-1:0]   num_hi;
    logic                   ovf_now;
    logic [DEN_W:0]         rem_shift;
    logic [DEN_W:0]         rem_diff;
    logic                   rem_ge;
    logic [Q_W:0]           q_sum;
    logic [Q_W-1:0]         q_rnd;
    logic                   sat_pos;
    logic                   sat_neg;
    logic [POS_W-1:0]       val_next;

    always_comb begin
        case (i_req.op)
            OP_RAD:  mb_sel = K_RAD;
            OP_RPM:  mb_sel = K_RPM;
            default: mb_sel = r_kms;
        endcase
    end

    // Align the product to the doubled quotient scale
    always_comb begin
        case (r_op)
            OP_RAD:  num_aligned = NUM_W'(r_acc) >> SH_RAD;
            OP_RPM:  num_aligned = NUM_W'(r_acc) << SH_RPM;
            OP_MPS:  num_aligned = NUM_W'(r_acc) >> SH_MPS;
            default: num_aligned = NUM_W'(r_acc);
        endcase
    end

    assign num_hi  = num_aligned[NUM_W-1:Q_W];
    assign ovf_now = num_hi >= {{(NUM_W-Q_W-DEN_W){1'b0}}, i_den};

    assign rem_shift = {r_rem, r_num[Q_W-1]};
    assign rem_ge    = rem_shift >= {1'b0, i_den};
    assign rem_diff  = rem_shift - {1'b0, i_den};

    // Round half away from zero: floor((floor(2A/B) + 1) / 2), then saturate
    assign q_sum   = {1'b0, r_num} + {{Q_W{1'b0}}, 1'b1};
    assign q_rnd   = q_sum[Q_W:1];
    assign sat_pos = r_ovf || (|q_rnd[Q_W-1:POS_W-1]);
    assign sat_neg = r_ovf || (|q_rnd[Q_W-1:POS_W])
                     || (q_rnd[POS_W-1] && (|q_rnd[POS_W-2:0]));

    always_comb begin
        if (r_neg) begin
            val_next = sat_neg ? {1'b1, {(POS_W-1){1'b0}}}
                               : {POS_W{1'b0}} - q_rnd[POS_W-1:0];
        end else begin
            val_next = sat_pos ? {1'b0, {(POS_W-1){1'b1}}} : q_rnd[POS_W-1:0];
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            U_IDLE: begin
                if (i_req.start) n_state = U_MUL;
            end
            U_MUL: begin
                if (r_step == STEP_W'(MAG_W - 1)) begin
                    n_state = (r_op == OP_KMS) ? U_FIN : U_CHK;
                end
            end
            U_CHK: begin
                n_state = ovf_now ? U_RND : U_DIV;
            end
            U_DIV: begin
                if (r_step == STEP_W'(Q_W - 1)) n_state = U_RND;
            end
            U_RND: begin
                n_state = U_FIN;
            end
            U_FIN: begin
                n_state = U_IDLE;
            end
            default: begin
                n_state = U_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= U_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            U_IDLE: begin
                if (i_req.start) begin
                    r_op   <= i_req.op;
                    r_neg  <= i_req.neg;
                    r_acc  <= '0;
                    r_step <= '0;
                    if (i_req.op == OP_KMS) begin
                        r_ma <= MAG_W'(i_radius);
                        r_mb <= K_RAD;
                    end else begin
                        r_ma <= i_req.mag;
                        r_mb <= mb_sel;
                    end
                end
            end
            U_MUL: begin
                r_acc  <= {r_acc[PROD_W-2:0], 1'b0}
                          + (r_ma[MAG_W-1] ? PROD_W'(r_mb) : {PROD_W{1'b0}});
                r_ma   <= {r_ma[MAG_W-2:0], 1'b0};
                r_step <= r_step + 1'b1;
            end
            U_CHK: begin
                r_ovf  <= ovf_now;
                r_rem  <= num_hi[DEN_W-1:0];
                r_num  <= num_aligned[Q_W-1:0];
                r_step <= '0;
            end
            U_DIV: begin
                r_rem  <= rem_ge ? rem_diff[DEN_W-1:0] : rem_shift[DEN_W-1:0];
                r_num  <= {r_num[Q_W-2:0], rem_ge};
                r_step <= r_step + 1'b1;
            end
            U_RND: begin
                r_val <= val_next;
            end
            U_FIN: begin
                if (r_op == OP_KMS) r_kms <= r_acc[K_W-1:0];
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_rsp.done  = (r_state == U_FIN);
        o_rsp.value = r_val;
    end

`ifndef NO_ASSERTIONS
    a_start_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> r_state == U_IDLE)
        else $error("speed unit started while busy");

    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == U_DIV |-> r_rem < i_den)
        else $error("division remainder not below divisor");
`endif

endmodule

// File: design/dual_quadrature_velocity_estimator.sv
`timescale 1ns / 1ps
// Two-wheel quadrature position counter and speed estimator. Each input
// transaction carries one command: an encoder edge (count +1 when A and B
// differ, -1 when equal, reversed by the wheel's invert bit, wrapping), an
// update request with a millisecond timestamp, a count load for one wheel,
// or a reset that clears counts and speeds and stamps the time. Every
// transaction yields exactly one output transaction holding both counts,
// the six stored speeds (rad/s, rpm, m/s per wheel, signed Q16.16, rounded
// half away from zero and saturated) and a flag set when this transaction
// recomputed the speeds. Edge, load, reset and early update transactions
// are accepted, then load the output register. An update that recomputes
// uses one shared serial arithmetic unit: a 32-step wheel-radius product,
// then per speed 32 multiply steps, an overflow check, 34 divide steps and
// rounding; a speed whose quotient overflows the divider skips its divide
// and saturates. The next input transaction is accepted while the previous
// result still waits in the output register. Configuration registers (index
// 0 counts per rev, 1 update period, 2 wheel radius, 3 left invert, 4 right
// invert) must be written only while idle; the block does not check this.
module dual_quadrature_velocity_estimator
    import dqve_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,

    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [CMD_W-1:0]     i_cmd,
    input  logic                 i_side,
    input  logic                 i_level_a,
    input  logic                 i_level_b,
    input  logic signed [31:0]   i_new_count,
    input  logic [31:0]          i_now_ms,

    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic signed [31:0]   o_left_count,
    output logic signed [31:0]   o_right_count,
    output logic signed [31:0]   o_left_rad_per_s,
    output logic signed [31:0]   o_left_rev_per_min,
    output logic signed [31:0]   o_left_metre_per_s,
    output logic signed [31:0]   o_right_rad_per_s,
    output logic signed [31:0]   o_right_rev_per_min,
    output logic signed [31:0]   o_right_metre_per_s,
    output logic                 o_recomputed
);

    typedef enum logic [4:0] {
        T_IDLE  = 5'b00001,
        T_DEN   = 5'b00010,
        T_ISSUE = 5'b00100,
        T_WAIT  = 5'b01000,
        T_EMIT  = 5'b10000
    } t_state;

    t_state r_state, n_state;

    // Configuration
    logic [CFG_W-1:0] r_cpr;
    logic [CFG_W-1:0] r_period;
    logic [CFG_W-1:0] r_radius;
    logic             r_inv [2];

    // Architectural state
    logic [POS_W-1:0] r_pos   [2];
    logic [POS_W-1:0] r_last  [2];
    logic [POS_W-1:0] r_stamp;
    logic [POS_W-1:0] r_vel   [2][3];

    // Update working registers
    logic [POS_W-1:0] r_dt;
    logic [DEN_W-1:0] r_den;
    logic [MAG_W-1:0] r_mag [2];
    logic             r_neg [2];
    t_op              r_op;
    logic             r_wsel;
    logic             r_recomp;

    // Output register
    logic             r_out_valid;
    logic [POS_W-1:0] r_out_count [2];
    logic [POS_W-1:0] r_out_vel   [2][3];
    logic             r_out_recomp;

    logic             in_accept;
    logic             out_take;
    logic [POS_W-1:0] dt_now;
    logic             upd_go;
    logic             edge_up;
    logic [CFG_W-1:0] cpr_eff;
    logic [DEN_W-1:0] den_prod;
    logic [POS_W-1:0] delta [2];
    t_speed_req       req;
    t_speed_rsp       rsp;

    assign o_in_stall = (r_state != T_IDLE);
    assign in_accept  = i_in_valid && (r_state == T_IDLE);
    // The output register is free, or its transaction completes this cycle
    assign out_take   = !r_out_valid || !i_out_stall;

    assign dt_now  = i_now_ms - r_stamp;
    assign upd_go  = (dt_now != '0) && (dt_now >= POS_W'(r_period));
    assign edge_up = (i_level_a ^ i_level_b) ^ r_inv[i_side];

    // A zero count per revolution behaves as one
    assign cpr_eff  = (r_cpr == '0) ? {{(CFG_W-1){1'b0}}, 1'b1} : r_cpr;
    assign den_prod = cpr_eff * r_dt;

    always_comb begin
        for (int s = 0; s < 2; s++) begin
            delta[s] = r_pos[s] - r_last[s];
        end
    end

    // One speed at a time: both wheels share the serial unit
    always_comb begin
        req.start = (r_state == T_ISSUE);
        req.op    = r_op;
        req.mag   = r_mag[r_wsel];
        req.neg   = r_neg[r_wsel];
    end

    dqve_speed_unit u_speed (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (req),
        .i_den    (r_den),
        .i_radius (r_radius),
        .o_rsp    (rsp)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            T_IDLE: begin
                if (in_accept) begin
                    n_state = ((i_cmd == CMD_UPDATE) && upd_go) ? T_DEN : T_EMIT;
                end
            end
            T_DEN: begin
                n_state = T_ISSUE;
            end
            T_ISSUE: begin
                n_state = T_WAIT;
            end
            T_WAIT: begin
                if (rsp.done) begin
                    n_state = ((r_op == OP_MPS) && r_wsel) ? T_EMIT : T_ISSUE;
                end
            end
            T_EMIT: begin
                if (out_take) n_state = T_IDLE;
            end
            default: begin
                n_state = T_IDLE;
            end
        endcase
    end

    // Control, configuration and architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= T_IDLE;
            r_out_valid <= 1'b0;
            r_cpr       <= CPR_RESET;
            r_period    <= PERIOD_RESET;
            r_radius    <= RADIUS_RESET;
            r_inv       <= '{default: 1'b0};
            r_pos       <= '{default: '0};
            r_last      <= '{default: '0};
            r_stamp     <= '0;
            r_vel       <= '{default: '0};
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_CPR:    r_cpr    <= i_cfg_data;
                    CFG_PERIOD: r_period <= i_cfg_data;
                    CFG_RADIUS: r_radius <= i_cfg_data;
                    CFG_LINV:   r_inv[0] <= i_cfg_data[0];
                    CFG_RINV:   r_inv[1] <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end

            if (in_accept) begin
                unique case (i_cmd)
                    CMD_EDGE: begin
                        r_pos[i_side] <= r_pos[i_side]
                            + (edge_up ? {{(POS_W-1){1'b0}}, 1'b1} : {POS_W{1'b1}});
                    end
                    CMD_UPDATE: begin
                        // Take the new sample point now; speeds follow
                        if (upd_go) begin
                            r_last[0] <= r_pos[0];
                            r_last[1] <= r_pos[1];
                            r_stamp   <= i_now_ms;
                        end
                    end
                    CMD_SET: begin
                        r_pos[i_side]  <= i_new_count;
                        r_last[i_side] <= i_new_count;
                    end
                    CMD_RESET: begin
                        r_pos   <= '{default: '0};
                        r_last  <= '{default: '0};
                        r_vel   <= '{default: '0};
                        r_stamp <= i_now_ms;
                    end
                    default: begin
                    end
                endcase
            end

            if ((r_state == T_WAIT) && rsp.done && (r_op != OP_KMS)) begin
                r_vel[r_wsel][r_op] <= rsp.value;
            end

            if ((r_state == T_EMIT) && out_take) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Working registers and output payload
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_recomp <= (i_cmd == CMD_UPDATE) && upd_go;
            r_dt     <= dt_now;
            r_op     <= OP_KMS;
            r_wsel   <= 1'b0;
            for (int s = 0; s < 2; s++) begin
                r_neg[s] <= delta[s][POS_W-1];
                r_mag[s] <= delta[s][POS_W-1] ? ({MAG_W{1'b0}} - delta[s]) : delta[s];
            end
        end

        if (r_state == T_DEN) begin
            r_den <= den_prod;
        end

        // Advance: radius product, then rad, rpm, m/s for left, then right
        if ((r_state == T_WAIT) && rsp.done) begin
            case (r_op)
                OP_KMS: r_op <= OP_RAD;
                OP_RAD: r_op <= OP_RPM;
                OP_RPM: r_op <= OP_MPS;
                default: begin
                    r_op   <= OP_RAD;
                    r_wsel <= 1'b1;
                end
            endcase
        end

        if ((r_state == T_EMIT) && out_take) begin
            r_out_count  <= r_pos;
            r_out_vel    <= r_vel;
            r_out_recomp <= r_recomp;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_left_count        = r_out_count[0];
    assign o_right_count       = r_out_count[1];
    assign o_left_rad_per_s    = r_out_vel[0][0];
    assign o_left_rev_per_min  = r_out_vel[0][1];
    assign o_left_metre_per_s  = r_out_vel[0][2];
    assign o_right_rad_per_s   = r_out_vel[1][0];
    assign o_right_rev_per_min = r_out_vel[1][1];
    assign o_right_metre_per_s = r_out_vel[1][2];
    assign o_recomputed        = r_out_recomp;

`ifndef NO_ASSERTIONS
    a_done_while_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp.done |-> r_state == T_WAIT)
        else $error("speed result arrived outside the wait state");

    a_short_cmd_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && (i_cmd != CMD_UPDATE) |=> r_state == T_EMIT)
        else $error("non-update transaction did not go straight to emit");
`endif

endmodule

// File: tb/tb_dual_quadrature_velocity_estimator.sv
`timescale 1ns / 1ps
module tb_dual_quadrature_velocity_estimator;
    import dqve_pkg::*;

    // Clock, reset and run limits
    localparam int HALF_PERIOD_NS   = 6;
    localparam int RESET_CYCLES     = 6;
    localparam int CYCLE_LIMIT      = 1_500_000;
    localparam int TAIL_CYCLES      = 600;      // longer than one recomputing update
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int RANDOM_PER_PHASE = 300;
    localparam int MAX_REPORTED     = 10;

    // Speed arithmetic: wide enough for magnitude * 1000 * 2pi(Q29) * radius << 17
    localparam int WIDE_W = 160;
    localparam logic [WIDE_W-1:0] K_RAD_Q29 = 160'd3373259426000;  // 1000 * round(2pi*2^29)
    localparam logic [WIDE_W-1:0] K_RPM     = 160'd60000;
    localparam logic [WIDE_W-1:0] SAT_POS   = 160'h7FFF_FFFF;
    localparam logic [WIDE_W-1:0] SAT_NEG   = 160'h8000_0000;

    localparam logic [15:0] CPR_AT_RESET    = 16'd1320;
    localparam logic [15:0] PERIOD_AT_RESET = 16'd50;
    localparam logic [15:0] RADIUS_AT_RESET = 16'd2130;

    // One input transaction
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             side;
        logic             level_a;
        logic             level_b;
        logic [31:0]      new_count;
        logic [31:0]      now_ms;
    } encoder_cmd_t;

    // One output transaction: word 0/1 counts, 2..7 speeds
    typedef struct packed {
        logic [7:0][31:0] word;
        logic             recomputed;
    } wheel_report_t;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    logic [CMD_W-1:0]     i_cmd = CMD_EDGE;
    logic                 i_side = 1'b0;
    logic                 i_level_a = 1'b0;
    logic                 i_level_b = 1'b0;
    logic signed [31:0]   i_new_count = '0;
    logic [31:0]          i_now_ms = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic signed [31:0]   o_left_count;
    logic signed [31:0]   o_right_count;
    logic signed [31:0]   o_left_rad_per_s;
    logic signed [31:0]   o_left_rev_per_min;
    logic signed [31:0]   o_left_metre_per_s;
    logic signed [31:0]   o_right_rad_per_s;
    logic signed [31:0]   o_right_rev_per_min;
    logic signed [31:0]   o_right_metre_per_s;
    logic                 o_recomputed;

    dual_quadrature_velocity_estimator DUT (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_in_valid          (i_in_valid),
        .o_in_stall          (o_in_stall),
        .i_cmd               (i_cmd),
        .i_side              (i_side),
        .i_level_a           (i_level_a),
        .i_level_b           (i_level_b),
        .i_new_count         (i_new_count),
        .i_now_ms            (i_now_ms),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_left_count        (o_left_count),
        .o_right_count       (o_right_count),
        .o_left_rad_per_s    (o_left_rad_per_s),
        .o_left_rev_per_min  (o_left_rev_per_min),
        .o_left_metre_per_s  (o_left_metre_per_s),
        .o_right_rad_per_s   (o_right_rad_per_s),
        .o_right_rev_per_min (o_right_rev_per_min),
        .o_right_metre_per_s (o_right_metre_per_s),
        .o_recomputed        (o_recomputed)
    );

    // Predictor copy of the registers
    logic [15:0] cpr = CPR_AT_RESET;
    logic [15:0] period_ms = PERIOD_AT_RESET;
    logic [15:0] radius_q16 = RADIUS_AT_RESET;
    logic        inv_left = 1'b0;
    logic        inv_right = 1'b0;

    // Predictor copy of the block state
    logic [31:0] pos_count [2] = '{32'd0, 32'd0};
    logic [31:0] sample_count [2] = '{32'd0, 32'd0};
    logic [31:0] stamp_ms = 32'd0;
    logic [31:0] speed [6] = '{32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0};

    encoder_cmd_t  pending_cmds [$];
    wheel_report_t expected_reports [$];
    encoder_cmd_t  next_cmd;

    string report_field [9] = '{"left_count", "right_count", "left_rad_per_s",
                                "left_rev_per_min", "left_metre_per_s", "right_rad_per_s",
                                "right_rev_per_min", "right_metre_per_s", "recomputed"};

    int unsigned n_cmds_queued = 0;
    int unsigned n_cmds_taken = 0;
    int unsigned n_reports_checked = 0;
    int unsigned n_recomputes = 0;
    int unsigned n_mismatches = 0;
    int unsigned cycle_count = 0;
    int unsigned send_idle_pct = 12;
    int unsigned recv_stall_pct = 65;
    int unsigned hold_at_cmd = 32'hFFFF_FFFF;
    int unsigned hold_left = 0;
    logic        hold_done = 1'b0;
    logic        in_accepted = 1'b0;
    logic [31:0] gen_now = 32'd0;

    // ------------------------------------------------------------------
    // Clock: 12 ns period
    // ------------------------------------------------------------------
    always begin
        #HALF_PERIOD_NS i_clk = 1'b1;
        #HALF_PERIOD_NS i_clk = 1'b0;
    end

    // Hard stop if the block hangs or runs far too slow
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Mismatches found");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Speed scaling: round-half-away quotient from the doubled form
    // (2*A + B) / (2*B), then saturate with the sign of the delta.
    // ------------------------------------------------------------------
    function automatic logic [31:0] scaled_speed(input logic [31:0] mag, input logic neg,
                                                 input logic [WIDE_W-1:0] kmul,
                                                 input logic [47:0] den, input int dshift);
        logic [WIDE_W-1:0] num;
        logic [WIDE_W-1:0] divisor;
        logic [WIDE_W-1:0] q;
        num = ((WIDE_W'(mag) * kmul) << (FRAC_BITS + 1)) + (WIDE_W'(den) << dshift);
        divisor = WIDE_W'(den) << (dshift + 1);
        q = num / divisor;
        if (neg) begin
            if (q > SAT_NEG)
                q = SAT_NEG;
            return 32'd0 - q[31:0];
        end
        if (q > SAT_POS)
            q = SAT_POS;
        return q[31:0];
    endfunction

    // Advance the predictor by the transaction on the input ports and
    // queue the report it must produce.
    task automatic predict_report();
        logic [31:0]   dt;
        logic [31:0]   delta;
        logic [31:0]   mag;
        logic [47:0]   den;
        logic [15:0]   cpr_eff;
        logic          up;
        logic          neg;
        wheel_report_t rpt;
        int            s;
        rpt.recomputed = 1'b0;
        case (i_cmd)
            CMD_EDGE: begin
                up = (i_level_a != i_level_b) != (i_side ? inv_right : inv_left);
                pos_count[i_side] = pos_count[i_side] + (up ? 32'd1 : 32'hFFFF_FFFF);
            end
            CMD_UPDATE: begin
                dt = i_now_ms - stamp_ms;
                if (dt != 32'd0 && dt >= 32'(period_ms)) begin
                    // zero counts per rev behaves as one
                    cpr_eff = (cpr == 16'd0) ? 16'd1 : cpr;
                    den = 48'(cpr_eff) * 48'(dt);
                    for (s = 0; s < 2; s++) begin
                        delta = pos_count[s] - sample_count[s];
                        neg = delta[31];
                        mag = neg ? (32'd0 - delta) : delta;
                        sample_count[s] = pos_count[s];
                        speed[3*s]   = scaled_speed(mag, neg, K_RAD_Q29, den, 29);
                        speed[3*s+1] = scaled_speed(mag, neg, K_RPM, den, 0);
                        speed[3*s+2] = scaled_speed(mag, neg,
                                                    K_RAD_Q29 * WIDE_W'(radius_q16), den, 45);
                    end
                    stamp_ms = i_now_ms;
                    rpt.recomputed = 1'b1;
                    n_recomputes++;
                end
            end
            CMD_SET: begin
                pos_count[i_side] = i_new_count;
                sample_count[i_side] = i_new_count;
            end
            default: begin
                for (s = 0; s < 2; s++) begin
                    pos_count[s] = 32'd0;
                    sample_count[s] = 32'd0;
                end
                for (s = 0; s < 6; s++)
                    speed[s] = 32'd0;
                stamp_ms = i_now_ms;
            end
        endcase
        rpt.word[0] = pos_count[0];
        rpt.word[1] = pos_count[1];
        for (s = 0; s < 6; s++)
            rpt.word[2+s] = speed[s];
        expected_reports.push_back(rpt);
    endtask

    task automatic flag_error(input string msg);
        n_mismatches++;
        if (n_mismatches <= MAX_REPORTED)
            $display("[%0t] ERROR: %s", $realtime, msg);
    endtask

    // Compare the report on the output ports with the oldest expectation
    task automatic check_report();
        wheel_report_t seen;
        wheel_report_t want;
        int            f;
        seen.word[0] = o_left_count;
        seen.word[1] = o_right_count;
        seen.word[2] = o_left_rad_per_s;
        seen.word[3] = o_left_rev_per_min;
        seen.word[4] = o_left_metre_per_s;
        seen.word[5] = o_right_rad_per_s;
        seen.word[6] = o_right_rev_per_min;
        seen.word[7] = o_right_metre_per_s;
        seen.recomputed = o_recomputed;
        if (expected_reports.size() == 0) begin
            flag_error($sformatf("result with nothing pending (left_count %0d)",
                                 $signed(seen.word[0])));
        end else begin
            want = expected_reports.pop_front();
            n_reports_checked++;
            for (f = 0; f < 8; f++) begin
                if (seen.word[f] !== want.word[f])
                    flag_error($sformatf("result %0d %s: expected %0d (0x%08h), got %0d (0x%08h)",
                                         n_reports_checked, report_field[f],
                                         $signed(want.word[f]), want.word[f],
                                         $signed(seen.word[f]), seen.word[f]));
            end
            if (seen.recomputed !== want.recomputed)
                flag_error($sformatf("result %0d %s: expected %0b, got %0b", n_reports_checked,
                                     report_field[8], want.recomputed, seen.recomputed));
        end
    endtask

    // ------------------------------------------------------------------
    // Monitor: sample both handshakes on the rising edge. Check the
    // output first; an input taken on the same edge is always younger.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        in_accepted <= i_rst_n && i_in_valid && !o_in_stall;
        if (i_rst_n && o_out_valid && !i_out_stall)
            check_report();
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            predict_report();
            n_cmds_taken++;
        end
    end

    // ------------------------------------------------------------------
    // Driver: change inputs on the falling edge. Hold the payload until
    // the transaction is taken, then advance or idle at random.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_in_valid || in_accepted)) begin
            if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                next_cmd = pending_cmds.pop_front();
                i_in_valid  <= 1'b1;
                i_cmd       <= next_cmd.cmd;
                i_side      <= next_cmd.side;
                i_level_a   <= next_cmd.level_a;
                i_level_b   <= next_cmd.level_b;
                i_new_count <= next_cmd.new_count;
                i_now_ms    <= next_cmd.now_ms;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stall, plus one long hold-off once the armed
    // command count is reached so the block backs up into its input.
    always @(negedge i_clk) begin
        if (!hold_done && n_cmds_taken >= hold_at_cmd) begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left = hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic queue_cmd(input logic [CMD_W-1:0] cmd, input logic side, input logic a,
                             input logic b, input logic [31:0] count, input logic [31:0] now);
        encoder_cmd_t c;
        c.cmd = cmd;
        c.side = side;
        c.level_a = a;
        c.level_b = b;
        c.new_count = count;
        c.now_ms = now;
        pending_cmds.push_back(c);
        n_cmds_queued++;
    endtask

    // Edge with random ignored fields
    task automatic queue_edge(input logic side, input logic a, input logic b);
        queue_cmd(CMD_EDGE, side, a, b, $urandom, $urandom);
    endtask

    // Update or reset with random ignored fields
    task automatic queue_timed(input logic [CMD_W-1:0] cmd, input logic [31:0] now);
        queue_cmd(cmd, $urandom_range(1), $urandom_range(1), $urandom_range(1), $urandom, now);
    endtask

    task automatic queue_set(input logic side, input logic [31:0] count);
        queue_cmd(CMD_SET, side, $urandom_range(1), $urandom_range(1), count, $urandom);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        case (idx)
            CFG_CPR:    cpr = val;
            CFG_PERIOD: period_ms = val;
            CFG_RADIUS: radius_q16 = val;
            CFG_LINV:   inv_left = val[0];
            CFG_RINV:   inv_right = val[0];
            default:    ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic apply_config(input logic [15:0] cpr_v, input logic [15:0] period_v,
                                input logic [15:0] radius_v, input logic linv_v,
                                input logic rinv_v);
        write_reg(CFG_CPR, cpr_v);
        write_reg(CFG_PERIOD, period_v);
        write_reg(CFG_RADIUS, radius_v);
        write_reg(CFG_LINV, {15'd0, linv_v});
        write_reg(CFG_RINV, {15'd0, rinv_v});
    endtask

    // Wait until every queued command is taken and every result checked
    task automatic drain();
        while (n_cmds_taken != n_cmds_queued || expected_reports.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // Mostly well-formed traffic: edge bursts biased to one direction,
    // updates spaced at or past the period, a few early updates, loads
    // and resets; the rest is fully random noise.
    task automatic queue_random_cmds(input int count);
        int unsigned r;
        logic        a;
        logic        fwd;
        logic [31:0] now;
        gen_now = stamp_ms;
        fwd = $urandom_range(1);
        repeat (count) begin
            r = $urandom_range(99);
            if (r < 60) begin
                a = $urandom_range(1);
                if ($urandom_range(19) == 0)
                    fwd = !fwd;
                queue_edge($urandom_range(1), a, ($urandom_range(9) < 8) ? (a ^ fwd) : a);
            end else if (r < 78) begin
                gen_now = gen_now + 32'(period_ms) + $urandom_range(3);
                queue_timed(CMD_UPDATE, gen_now);
            end else if (r < 84) begin
                // usually too early: elapsed up to the period, possibly zero
                queue_timed(CMD_UPDATE, gen_now + $urandom_range(32'(period_ms)));
            end else if (r < 90) begin
                case ($urandom_range(3))
                    0:       queue_set($urandom_range(1), 32'h7FFF_FFFF);
                    1:       queue_set($urandom_range(1), 32'h8000_0000);
                    default: queue_set($urandom_range(1), $urandom_range(2000) - 1000);
                endcase
            end else if (r < 93) begin
                gen_now = gen_now + $urandom_range(100);
                queue_timed(CMD_RESET, gen_now);
            end else begin
                now = $urandom;
                queue_cmd($urandom_range(3), $urandom_range(1), $urandom_range(1),
                          $urandom_range(1), $urandom, now);
                if (pending_cmds[$].cmd == CMD_RESET || pending_cmds[$].cmd == CMD_UPDATE)
                    gen_now = now;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence of the run
    // ------------------------------------------------------------------
    initial begin
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed, reset register values: direction table, early and
        // accepted updates, count wrap at both ends, timestamp wrap.
        queue_timed(CMD_RESET, 32'd1000);
        queue_edge(1'b0, 1'b0, 1'b0);
        queue_edge(1'b0, 1'b0, 1'b1);
        queue_edge(1'b0, 1'b1, 1'b0);
        queue_edge(1'b0, 1'b1, 1'b1);
        queue_edge(1'b0, 1'b0, 1'b1);
        queue_edge(1'b1, 1'b1, 1'b1);
        queue_timed(CMD_UPDATE, 32'd1000);
        queue_timed(CMD_UPDATE, 32'd1049);
        queue_timed(CMD_UPDATE, 32'd1050);
        queue_set(1'b0, 32'h7FFF_FFFF);
        queue_set(1'b1, 32'h8000_0000);
        queue_edge(1'b0, 1'b1, 1'b0);
        queue_edge(1'b1, 1'b0, 1'b0);
        queue_timed(CMD_UPDATE, 32'd1100);
        queue_timed(CMD_RESET, 32'hFFFF_FFF0);
        queue_edge(1'b1, 1'b0, 1'b1);
        queue_timed(CMD_UPDATE, 32'h0000_0040);
        queue_timed(CMD_UPDATE, 32'hFFFF_FFFF);
        drain();

        // Lowest nonzero scale, largest radius, both wheels inverted:
        // speeds saturate in both directions.
        apply_config(16'd1, 16'd1, 16'hFFFF, 1'b1, 1'b1);
        queue_timed(CMD_RESET, 32'd0);
        repeat (6) queue_edge(1'b0, 1'b1, 1'b1);
        repeat (2) queue_edge(1'b1, 1'b1, 1'b0);
        queue_timed(CMD_UPDATE, 32'd1);
        queue_timed(CMD_UPDATE, 32'd2);
        drain();

        // Zero scale, zero period and zero radius
        apply_config(16'd0, 16'd0, 16'd0, 1'b0, 1'b0);
        queue_edge(1'b0, 1'b1, 1'b0);
        queue_timed(CMD_UPDATE, 32'd6);
        queue_timed(CMD_UPDATE, 32'd6);
        drain();

        // Random phase: sender idles lightly, receiver stalls heavily
        apply_config($urandom_range(64, 1), $urandom_range(16, 1), $urandom_range(65535, 1),
                     $urandom_range(1), $urandom_range(1));
        send_idle_pct = 12;
        recv_stall_pct = 65;
        queue_random_cmds(RANDOM_PER_PHASE);
        drain();

        // Random phase at the top of every range, idle ratios swapped
        apply_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0);
        send_idle_pct = 65;
        recv_stall_pct = 12;
        queue_random_cmds(RANDOM_PER_PHASE);
        drain();

        // Random phase with no idling; arm the long output hold early
        apply_config(16'd1, 16'd1, 16'd1, 1'b0, 1'b1);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_at_cmd = n_cmds_taken + 20;
        queue_random_cmds(RANDOM_PER_PHASE);
        drain();

        // Let any stray result show up before closing
        repeat (TAIL_CYCLES) @(negedge i_clk);

        $display("Covered %0d commands and %0d checked results, %0d of them recomputing",
                 n_cmds_taken, n_reports_checked, n_recomputes);
        $display("Settings: reset, minimum, zero and maximum scales; %0d-cycle output hold",
                 LONG_HOLD_CYCLES);
        if (n_mismatches == 0 && expected_reports.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("%0d errors, %0d results outstanding", n_mismatches,
                     expected_reports.size());
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
